[rtl/assert_macros.svh]
// Assertion macros shared by checker code
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property on the rising clock, disabled during reset
`define VFA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a property on the rising clock at all times
`define VFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/vfa_pkg.sv]
// Package: types, opcodes and the binary32 adder pieces for the vector add unit
`timescale 1ns / 1ps
`default_nettype none
package vfa_pkg;
  localparam int NumVregsDef = 32;
  localparam int NumLanes    = 4;
  localparam logic [31:0] QNan = 32'h7FC0_0000;

  typedef enum logic [3:0] {
    OpLoad = 4'd0, OpAbs = 4'd1, OpAdd = 4'd2, OpAddI = 4'd3, OpAddQ = 4'd4,
    OpAddBc = 4'd5, OpAdda = 4'd6, OpAddaI = 4'd7, OpAddaQ = 4'd8, OpAddaBc = 4'd9
  } op_e;

  typedef enum logic [1:0] {DstVreg = 2'd0, DstAcc = 2'd1, DstNone = 2'd2} dst_sel_e;

  // input word: one operation
  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  dest_mask;
    logic [4:0]  src_reg;
    logic [4:0]  tgt_reg;
    logic [4:0]  dst_reg;
    logic [1:0]  bc_lane;
    logic [31:0] load_x;
    logic [31:0] load_y;
    logic [31:0] load_z;
    logic [31:0] load_w;
  } op_word_t;

  // result word: four lanes of the written destination
  typedef struct packed {
    logic [31:0] res_x;
    logic [31:0] res_y;
    logic [31:0] res_z;
    logic [31:0] res_w;
  } lane_word_t;

  // first adder stage output: aligned mantissas and special results
  typedef struct packed {
    logic        special;
    logic [31:0] special_val;
    logic        sign;
    logic        sub;
    logic [7:0]  exp;
    logic [26:0] ma;
    logic [26:0] mb;
  } align_t;

  // lane control for the write-back
  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] mask;
    logic [4:0] wr_idx;
    dst_sel_e   dsel;
  } ctl_t;

  function automatic align_t f32_align(input logic [31:0] a_in, input logic [31:0] b_in);
    align_t      r;
    logic [31:0] a, b;
    logic [7:0]  ea, eb, d;
    logic [26:0] ma, mb, sh, lost;
    logic        nan_a, nan_b;
    r = '0;
    nan_a = (a_in[30:23] == 8'hFF) && (a_in[22:0] != 23'd0);
    nan_b = (b_in[30:23] == 8'hFF) && (b_in[22:0] != 23'd0);
    if (a_in[30:0] < b_in[30:0]) begin
      a = b_in; b = a_in;
    end else begin
      a = a_in; b = b_in;
    end
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0], 3'b000};
    mb = {(b[30:23] != 8'd0), b[22:0], 3'b000};
    d = ea - eb;
    if (d >= 8'd27) begin
      sh = 27'd1;
    end else begin
      sh   = mb >> d;
      lost = mb & ((27'd1 << d) - 27'd1);
      sh   = sh | {26'd0, (lost != 27'd0)};
    end
    r.sign = a[31];
    r.sub  = a[31] ^ b[31];
    r.exp  = ea;
    r.ma   = ma;
    r.mb   = sh;
    if (nan_a || nan_b) begin
      r.special = 1'b1; r.special_val = QNan;
    end else if (a_in[30:23] == 8'hFF) begin
      r.special = 1'b1;
      r.special_val = ((b_in[30:23] == 8'hFF) && (a_in[31] != b_in[31])) ? QNan : a_in;
    end else if (b_in[30:23] == 8'hFF) begin
      r.special = 1'b1; r.special_val = b_in;
    end else if (a_in[30:0] == 31'd0 && b_in[30:0] == 31'd0) begin
      r.special = 1'b1; r.special_val = {a_in[31] & b_in[31], 31'd0};
    end else if (a_in[30:0] == 31'd0) begin
      r.special = 1'b1; r.special_val = b_in;
    end else if (b_in[30:0] == 31'd0) begin
      r.special = 1'b1; r.special_val = a_in;
    end
    return r;
  endfunction

  function automatic logic [31:0] f32_finish(input align_t r);
    logic [27:0] m;
    logic [9:0]  e;
    logic [4:0]  lz;
    logic [4:0]  room;
    logic [4:0]  shl;
    logic [2:0]  grs;
    logic [24:0] mr;
    logic [7:0]  ef;
    if (r.special) return r.special_val;
    e = {2'b00, r.exp};
    if (!r.sub) begin
      m = {1'b0, r.ma} + {1'b0, r.mb};
      if (m[27]) begin
        m = {1'b0, m[27:1]} | {27'd0, m[0]};
        e = e + 10'd1;
      end
    end else begin
      m = {1'b0, r.ma} - {1'b0, r.mb};
      if (m == 28'd0) return 32'd0;
      lz = 5'd0;
      for (int i = 26; i >= 0; i--) begin
        if (m[i] == 1'b1 && lz == 5'd0) lz = 5'(26 - i) + 5'd0;
      end
      if (m[26]) lz = 5'd0;
      room = (r.exp > 8'd26) ? 5'd26 : 5'(r.exp - 8'd1);
      shl  = (lz < room) ? lz : room;
      m = m << shl;
      e = e - {5'd0, shl};
    end
    grs = m[2:0];
    mr  = {1'b0, m[26:3]};
    if (grs > 3'd4 || (grs == 3'd4 && mr[0])) mr = mr + 25'd1;
    if (mr[24]) begin
      mr = mr >> 1;
      e  = e + 10'd1;
    end
    if (e >= 10'd255) return {r.sign, 31'h7F80_0000};
    ef = mr[23] ? e[7:0] : 8'd0;
    return {r.sign, ef, mr[22:0]};
  endfunction
endpackage
`default_nettype wire

[rtl/vfa_if.sv]
// Valid/ready channel interface carrying a generic payload
`timescale 1ns / 1ps
`default_nettype none
interface vfa_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/vfa_lane.sv]
// One lane: two-stage binary32 adder with abs and load bypass
`timescale 1ns / 1ps
`default_nettype none
module vfa_lane (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [3:0]  kind_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic [31:0] load_i,
  output logic [31:0]      res_o
);
  vfa_pkg::align_t al_q;
  logic [31:0]     byp_q;
  logic            use_byp_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      al_q      <= vfa_pkg::f32_align(a_i, b_i);
      use_byp_q <= (kind_i == vfa_pkg::OpLoad) || (kind_i == vfa_pkg::OpAbs);
      byp_q     <= (kind_i == vfa_pkg::OpLoad) ? load_i : {1'b0, a_i[30:0]};
    end
  end

  assign res_o = use_byp_q ? byp_q : vfa_pkg::f32_finish(al_q);
endmodule
`default_nettype wire

[rtl/vfa_merge.sv]
// Merge stage: masked lane write into register file or accumulator
`timescale 1ns / 1ps
`default_nettype none
module vfa_merge (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 we_i,
  input  wire vfa_pkg::ctl_t        ctl_i,
  input  wire logic [127:0]         lanes_i,
  input  wire logic [127:0]         old_i,
  output logic [127:0]              merged_o,
  output logic [127:0]              acc_o
);
  logic [127:0] acc_q;

  always_comb begin
    for (int k = 0; k < vfa_pkg::NumLanes; k++) begin
      merged_o[32*k +: 32] = (ctl_i.mask[k] && ctl_i.dsel != vfa_pkg::DstNone) ?
                             lanes_i[32*k +: 32] : old_i[32*k +: 32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (we_i && ctl_i.dsel == vfa_pkg::DstAcc) begin
      acc_q <= merged_o;
    end
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

[rtl/vector_float_add_masked.sv]
// Top level: four-lane masked binary32 vector add unit
// Usage:
//  - in_if carries one operation word (kind, mask, register indexes, load lanes).
//  - out_if returns one word per operation: the four lanes of the register that
//    the operation wrote (tgt_reg for abs, accumulator for adda, dst_reg else).
//  - APB port writes I (addr 0) and Q (addr 4); reads return them.
// Stage 1 reads operands and aligns mantissas in each lane; stage 2 adds,
// normalizes, rounds, merges the mask and writes the register file and the
// output register.
// Throughput: one word per cycle when results are taken, except that a word
// whose fs or ft is the register written in stage 2 waits until that write.
// Reset: register file, accumulator, I and Q clear to zero at once.
// Stall: the output register holds its word; the pipeline moves on only while
// the output register is free or being drained.
`timescale 1ns / 1ps
`default_nettype none
module vector_float_add_masked #(
  parameter int NumVregs = vfa_pkg::NumVregsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  vfa_if.sink              in_if,
  vfa_if.source            out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int IdxW = $clog2(NumVregs);

  logic [31:0]  i_q, q_q;
  logic [127:0] vregs_q [NumVregs];
  logic         s1_vld_q, out_vld_q;
  vfa_pkg::ctl_t ctl_q;
  logic [127:0] out_q;
  logic         adv;
  logic         hazard;
  logic [127:0] lanes, old, merged, acc;
  logic [127:0] fs_v, ft_v, opb;
  logic [127:0] ld;
  logic [31:0]  bcv;
  logic [3:0]   kind;
  logic [3:0]   sel;
  logic [IdxW-1:0] fs, ft, fd;
  vfa_pkg::ctl_t ctl_d;
  logic         wb;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      q_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == 1'b0) i_q <= pwdata;
      else q_q <= pwdata;
    end
  end
  assign prdata = paddr[2] ? q_q : i_q;

  assign kind = in_if.data.kind;
  assign fs   = in_if.data.src_reg[IdxW-1:0];
  assign ft   = in_if.data.tgt_reg[IdxW-1:0];
  assign fd   = in_if.data.dst_reg[IdxW-1:0];

  // operand register still being written by stage 2: hold the word until the write is done
  assign hazard = s1_vld_q && ctl_q.dsel == vfa_pkg::DstVreg &&
                  (ctl_q.wr_idx[IdxW-1:0] == fs || ctl_q.wr_idx[IdxW-1:0] == ft);

  // pipeline advances when output register free or drained
  assign adv         = !out_vld_q || out_if.ready;
  assign in_if.ready = adv && !hazard;
  assign wb          = s1_vld_q && adv;

  assign fs_v = vregs_q[fs];
  assign ft_v = vregs_q[ft];
  assign bcv  = ft_v[32*in_if.data.bc_lane +: 32];
  assign sel  = (kind >= vfa_pkg::OpAdda) ? kind - 4'd4 : kind;

  always_comb begin
    case (sel)
      vfa_pkg::OpAddI:  opb = {4{i_q}};
      vfa_pkg::OpAddQ:  opb = {4{q_q}};
      vfa_pkg::OpAddBc: opb = {4{bcv}};
      default:          opb = ft_v;
    endcase
  end

  always_comb begin
    ctl_d.kind = kind;
    ctl_d.mask = in_if.data.dest_mask;
    ctl_d.wr_idx = in_if.data.dst_reg;
    ctl_d.dsel = vfa_pkg::DstVreg;
    if (kind == vfa_pkg::OpAbs) begin
      ctl_d.wr_idx = in_if.data.tgt_reg;
    end else if (kind inside {[vfa_pkg::OpAdda:vfa_pkg::OpAddaBc]}) begin
      ctl_d.dsel = vfa_pkg::DstAcc;
    end else if (kind > vfa_pkg::OpAddaBc) begin
      ctl_d.dsel = vfa_pkg::DstNone;
    end
  end

  assign ld = {in_if.data.load_w, in_if.data.load_z, in_if.data.load_y, in_if.data.load_x};

  for (genvar k = 0; k < vfa_pkg::NumLanes; k++) begin : g_lane
    vfa_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .kind_i (kind),
      .a_i    (fs_v[32*k +: 32]),
      .b_i    (opb[32*k +: 32]),
      .load_i (ld[32*k +: 32]),
      .res_o  (lanes[32*k +: 32])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_if.valid && !hazard;
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) ctl_q <= ctl_d;
    if (wb) out_q <= merged;
  end

  assign old = (ctl_q.dsel == vfa_pkg::DstAcc) ? acc : vregs_q[ctl_q.wr_idx[IdxW-1:0]];

  vfa_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (wb),
    .ctl_i    (ctl_q),
    .lanes_i  (lanes),
    .old_i    (old),
    .merged_o (merged),
    .acc_o    (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumVregs; r++) vregs_q[r] <= '0;
    end else if (wb && ctl_q.dsel == vfa_pkg::DstVreg) begin
      vregs_q[ctl_q.wr_idx[IdxW-1:0]] <= merged;
    end
  end

  assign out_if.valid      = out_vld_q;
  assign out_if.data.res_x = out_q[31:0];
  assign out_if.data.res_y = out_q[63:32];
  assign out_if.data.res_z = out_q[95:64];
  assign out_if.data.res_w = out_q[127:96];
endmodule
`default_nettype wire

[rtl/vfa_checker.sv]
// Port-level checker for the vector add unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module vfa_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic pready
);
  `VFA_ASSERT(a_two_cycle, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> ##1 out_valid_i, "result missing")
  `VFA_ASSERT(a_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i, "result dropped")
  `VFA_ASSERT(a_rdy, clk_i, rst_ni, (out_valid_i && !out_ready_i) |-> !in_ready_i, "input taken while result stalled")
  `VFA_ASSERT_ALWAYS(a_pready, clk_i, pready, "pready low")
endmodule
bind vector_float_add_masked vfa_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .pready(pready)
);
`default_nettype wire
